@@ src/seeded_128bit_multiply_mix_hash_core_macros.svh @@
// Assertion helpers for the multiply-mix hash core.
`ifndef SEEDED_128BIT_MULTIPLY_MIX_HASH_CORE_MACROS_SVH
`define SEEDED_128BIT_MULTIPLY_MIX_HASH_CORE_MACROS_SVH

// Checked only while out of reset.
`define SH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/sh128_pkg.sv @@
package sh128_pkg;

    localparam logic [63:0] KEY_C0 = 64'h59757a7541696861;
    localparam logic [63:0] KEY_C1 = 64'h4d65694169686172;
    localparam logic [63:0] KEY_C2 = 64'h4d495a5553415741;
    localparam logic [63:0] KEY_C3 = 64'h494c4f5645594f55;
    localparam int unsigned XS_SHIFT = 33;
    localparam int unsigned SEED_ROT = 32;
    localparam int unsigned LANES    = 4;
    localparam int unsigned BUF_DEPTH = LANES - 1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_GRP_M1,
        S_GRP_M2,
        S_GRP_FOLD,
        S_GRP_CROSS,
        S_SGL_M1,
        S_SGL_M2,
        S_SGL_CROSS,
        S_TAIL_M1,
        S_TAIL_M2,
        S_FIN_M1,
        S_FIN_M2,
        S_A1_K0,
        S_A1_J1,
        S_A2_K1,
        S_A2_J0,
        S_PUSH
    } t_state;

    // Request to the shared multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    function automatic logic [63:0] rotl1(input logic [63:0] x);
        return {x[62:0], x[63]};
    endfunction

    function automatic logic [63:0] xs33(input logic [63:0] x);
        return x ^ (x >> XS_SHIFT);
    endfunction

endpackage

@@ src/sh128_mul.sv @@
module sh128_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sh128_pkg::t_mul_req i_req,
    output logic               o_done,
    output logic [127:0]       o_prod
);
    import sh128_pkg::*;

    logic [63:0]  r_a, r_b;
    logic [127:0] r_acc;
    logic [1:0]   r_step;
    logic         r_busy, r_done;
    logic [31:0]  a_part, b_part;
    logic [63:0]  pp;
    logic [6:0]   sh;
    logic [127:0] term;

    // One 32x32 partial product per cycle, low-low first.
    always_comb begin
        a_part = r_step[1] ? r_a[63:32] : r_a[31:0];
        b_part = r_step[0] ? r_b[63:32] : r_b[31:0];
        pp     = 64'(a_part) * 64'(b_part);
        if (r_step == 2'd3) begin
            sh = 7'd64;
        end else if (r_step == 2'd0) begin
            sh = 7'd0;
        end else begin
            sh = 7'd32;
        end
        term = {64'b0, pp} << sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc  <= r_acc + term;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ src/seeded_128bit_multiply_mix_hash_core.sv @@
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_word_low, i_word_high, i_byte_count, i_last
// output    out        o_valid / i_stall    o_hash_low, o_hash_high
// seed cfg  in         i_seed_we            i_seed
//
// A chunk that neither ends a message nor closes a group leaves the core idle.
// Each 64x64 multiply is four passes of one shared 32x32 unit.
// Closing a group: 8 multiplies, fold, cross step. A last chunk adds 2 multiplies
// per single fold or tail and a 6-multiply avalanche.
// Reset is synchronous, active low. A stalled result waits in the output register;
// new chunks are taken meanwhile and only the next result waits for it.
module seeded_128bit_multiply_mix_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [63:0] i_seed,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_word_low,
    input  logic [63:0] i_word_high,
    input  logic [4:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash_low,
    output logic [63:0] o_hash_high
);
    import sh128_pkg::*;

    t_state r_state, n_state;

    logic [63:0]  r_seed;
    logic [63:0]  r_lane_lo [LANES];
    logic [63:0]  r_lane_hi [LANES];
    logic [63:0]  r_acc1, r_acc2;
    logic [127:0] r_buf [BUF_DEPTH];   // {high, low}, undefined until written
    logic [1:0]   r_cnt;
    logic [1:0]   r_idx;
    logic [63:0]  r_wl, r_wh;          // current chunk, tail already masked
    logic [4:0]   r_bc;
    logic         r_last, r_tail;
    logic [63:0]  r_mlo, r_mhi;        // first product of a mix pair
    logic [63:0]  r_a1, r_a2;
    logic         r_issued;
    logic         r_ovalid;
    logic [63:0]  r_olo, r_ohi;

    t_mul_req     mreq;
    logic         mdone;
    logic [127:0] mprod;

    logic [63:0]  k0, k1, j0, j1;
    logic [63:0]  pm, py;
    logic         mul_state;
    logic         accept;
    logic [4:0]   bcs;
    logic         in_full, in_tail;
    logic [127:0] tmask;
    logic [63:0]  x_lo, x_hi;
    logic [63:0]  f1, f2;
    logic [63:0]  fin_lo, fin_hi, fin_a1;
    logic         push;
    t_state       after_body;

    sh128_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_done  (mdone),
        .o_prod  (mprod)
    );

    // Keys follow the live seed.
    assign k0 = KEY_C0 ^ r_seed;
    assign k1 = KEY_C1 ^ {r_seed[SEED_ROT-1:0], r_seed[63:SEED_ROT]};
    assign j0 = KEY_C2 ^ r_seed;
    assign j1 = KEY_C3;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // Count above 16 counts as 16; short non-last chunk counts as full.
    assign bcs     = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
    assign in_full = !i_last || (bcs == 5'd16);
    assign in_tail = !in_full && (bcs != 5'd0);
    assign tmask   = ~(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff << {bcs[3:0], 3'b000});

    // Product of the second multiply of a pair folded with the first.
    assign x_lo = mprod[63:0] ^ r_mlo;
    assign x_hi = mprod[127:64] ^ r_mhi;

    assign fin_lo = x_lo;
    assign fin_hi = x_hi;
    assign fin_a1 = fin_lo ^ fin_hi;

    // Pair operands for the mix steps.
    always_comb begin
        pm = r_wl;
        py = r_wh;
        if ((r_state == S_GRP_M1 || r_state == S_GRP_M2) && r_idx != 2'd3) begin
            pm = r_buf[r_idx][63:0];
            py = r_buf[r_idx][127:64];
        end else if (r_state == S_SGL_M1 || r_state == S_SGL_M2) begin
            pm = r_buf[r_idx][63:0];
            py = r_buf[r_idx][127:64];
        end
    end

    // Lane fold: three rotate-xor steps on each accumulator.
    always_comb begin
        f1 = r_acc1 ^ r_lane_lo[0];
        f2 = r_acc2 ^ r_lane_hi[0];
        for (int i = 1; i < LANES; i++) begin
            f1 = f1 ^ rotl1(f1) ^ r_lane_lo[i];
            f2 = f2 ^ rotl1(f2) ^ r_lane_hi[i];
        end
    end

    assign mul_state = (r_state == S_GRP_M1) || (r_state == S_GRP_M2) ||
                       (r_state == S_SGL_M1) || (r_state == S_SGL_M2) ||
                       (r_state == S_TAIL_M1) || (r_state == S_TAIL_M2) ||
                       (r_state == S_FIN_M1) || (r_state == S_FIN_M2) ||
                       (r_state == S_A1_K0) || (r_state == S_A1_J1) ||
                       (r_state == S_A2_K1) || (r_state == S_A2_J0);

    assign push = (r_state == S_PUSH) && !(r_ovalid && i_stall);

    always_comb begin
        after_body = r_tail ? S_TAIL_M1 : S_FIN_M1;
        n_state    = r_state;
        mreq.start = mul_state && !r_issued;
        mreq.a     = '0;
        mreq.b     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_full && r_cnt == 2'd3) begin
                        n_state = S_GRP_M1;
                    end else if (i_last) begin
                        if ((r_cnt != 2'd0) || in_full) begin
                            n_state = S_SGL_M1;
                        end else if (in_tail) begin
                            n_state = S_TAIL_M1;
                        end else begin
                            n_state = S_FIN_M1;
                        end
                    end
                end
            end
            S_GRP_M1, S_SGL_M1, S_TAIL_M1: begin
                mreq.a = pm ^ k0;
                mreq.b = py ^ k1;
                if (mdone) begin
                    n_state = (r_state == S_GRP_M1) ? S_GRP_M2 :
                              (r_state == S_SGL_M1) ? S_SGL_M2 : S_TAIL_M2;
                end
            end
            S_GRP_M2, S_SGL_M2, S_TAIL_M2: begin
                mreq.a = pm ^ j0;
                mreq.b = py ^ j1;
                if (mdone) begin
                    if (r_state == S_GRP_M2) begin
                        n_state = (r_idx == 2'd3) ? S_GRP_FOLD : S_GRP_M1;
                    end else if (r_state == S_SGL_M2) begin
                        n_state = S_SGL_CROSS;
                    end else begin
                        n_state = S_FIN_M1;
                    end
                end
            end
            S_GRP_FOLD: begin
                n_state = S_GRP_CROSS;
            end
            S_GRP_CROSS: begin
                n_state = r_last ? after_body : S_IDLE;
            end
            S_SGL_CROSS: begin
                n_state = ({1'b0, r_idx} + 3'd1 < {1'b0, r_cnt}) ? S_SGL_M1 : after_body;
            end
            S_FIN_M1: begin
                mreq.a = r_acc1;
                mreq.b = j0;
                if (mdone) begin
                    n_state = S_FIN_M2;
                end
            end
            S_FIN_M2: begin
                mreq.a = r_acc2;
                mreq.b = k0;
                if (mdone) begin
                    n_state = S_A1_K0;
                end
            end
            S_A1_K0: begin
                mreq.a = xs33(r_a1);
                mreq.b = k0;
                if (mdone) begin
                    n_state = S_A1_J1;
                end
            end
            S_A1_J1: begin
                mreq.a = xs33(r_a1);
                mreq.b = j1;
                if (mdone) begin
                    n_state = S_A2_K1;
                end
            end
            S_A2_K1: begin
                mreq.a = xs33(r_a2);
                mreq.b = k1;
                if (mdone) begin
                    n_state = S_A2_J0;
                end
            end
            S_A2_J0: begin
                mreq.a = xs33(r_a2);
                mreq.b = j0;
                if (mdone) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (push) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath and message state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= '0;
            r_acc1   <= KEY_C1;
            r_acc2   <= KEY_C0;
            r_cnt    <= 2'd0;
            r_idx    <= 2'd0;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_lane_lo[i] <= '0;
                r_lane_hi[i] <= '0;
            end
        end else begin
            if (i_seed_we) begin
                r_seed <= i_seed;
            end
            if (mreq.start) begin
                r_issued <= 1'b1;
            end else if (mdone) begin
                r_issued <= 1'b0;
            end
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_wl   <= in_tail ? (i_word_low & tmask[63:0]) : i_word_low;
                        r_wh   <= in_tail ? (i_word_high & tmask[127:64]) : i_word_high;
                        r_bc   <= bcs;
                        r_last <= i_last;
                        r_tail <= in_tail;
                        r_idx  <= 2'd0;
                        if (in_full && r_cnt == 2'd3) begin
                            r_cnt <= 2'd0;
                        end else if (in_full) begin
                            r_buf[r_cnt] <= {i_word_high, i_word_low};
                            r_cnt        <= r_cnt + 2'd1;
                        end
                    end
                end
                S_GRP_M1, S_SGL_M1, S_TAIL_M1, S_FIN_M1: begin
                    if (mdone) begin
                        r_mlo <= mprod[63:0];
                        r_mhi <= mprod[127:64];
                    end
                end
                S_GRP_M2: begin
                    if (mdone) begin
                        r_lane_lo[r_idx] <= r_lane_lo[r_idx] ^ x_lo;
                        r_lane_hi[r_idx] <= r_lane_hi[r_idx] ^ x_hi;
                        r_idx            <= r_idx + 2'd1;
                    end
                end
                S_GRP_FOLD: begin
                    r_acc1 <= f1;
                    r_acc2 <= f2;
                end
                S_GRP_CROSS, S_SGL_CROSS: begin
                    r_acc1 <= rotl1(r_acc1) + r_acc2;
                    r_acc2 <= rotl1(r_acc1) + rotl1(r_acc1) + r_acc2;
                    if (r_state == S_SGL_CROSS) begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_SGL_M2: begin
                    if (mdone) begin
                        r_acc1 <= r_acc1 ^ x_lo;
                        r_acc2 <= r_acc2 ^ x_hi;
                    end
                end
                S_TAIL_M2: begin
                    if (mdone) begin
                        r_acc1 <= r_acc1 ^ x_lo ^ {59'b0, r_bc};
                        r_acc2 <= r_acc2 ^ x_hi;
                    end
                end
                S_FIN_M2: begin
                    if (mdone) begin
                        r_a1 <= fin_a1;
                        r_a2 <= fin_hi + fin_a1;
                    end
                end
                S_A1_K0, S_A1_J1: begin
                    if (mdone) begin
                        r_a1 <= mprod[63:0];
                    end
                end
                S_A2_K1, S_A2_J0: begin
                    if (mdone) begin
                        r_a2 <= mprod[63:0];
                    end
                end
                S_PUSH: begin
                    if (push) begin
                        r_olo    <= xs33(r_a1);
                        r_ohi    <= xs33(r_a2);
                        r_acc1   <= KEY_C1;
                        r_acc2   <= KEY_C0;
                        r_cnt    <= 2'd0;
                        for (int i = 0; i < LANES; i++) begin
                            r_lane_lo[i] <= '0;
                            r_lane_hi[i] <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_hash_low  = r_olo;
    assign o_hash_high = r_ohi;

endmodule

@@ src/sh128_checker.sv @@
`include "seeded_128bit_multiply_mix_hash_core_macros.svh"

module sh128_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_last,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_hash_low,
    input logic [63:0] o_hash_high
);
    // Result holds while stalled.
    `SH_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid, "result dropped under stall")
    `SH_ASSERT(a_out_stable, o_valid && i_stall |=> $stable({o_hash_high, o_hash_low}), "result moved")
    // A taken last chunk makes the core busy next cycle.
    `SH_ASSERT(a_busy_after, i_valid && !o_stall && i_last |=> o_stall, "not busy after last")
    // Nothing comes out right after reset.
    `SH_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind seeded_128bit_multiply_mix_hash_core sh128_checker u_sh128_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .i_last      (i_last),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_hash_low  (o_hash_low),
    .o_hash_high (o_hash_high)
);

@@ tb/sv/seeded_128bit_multiply_mix_hash_core_tb.sv @@
module seeded_128bit_multiply_mix_hash_core_tb;
    import sh128_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_seed_we;
    logic [63:0] i_seed;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_word_low;
    logic [63:0] i_word_high;
    logic [4:0]  i_byte_count;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_hash_low;
    logic [63:0] o_hash_high;

    seeded_128bit_multiply_mix_hash_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_seed_we(i_seed_we), .i_seed(i_seed),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_word_low(i_word_low), .i_word_high(i_word_high),
        .i_byte_count(i_byte_count), .i_last(i_last),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_hash_low(o_hash_low), .o_hash_high(o_hash_high)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Predictor state: our own copy of the hash core's message state.
    logic [63:0] seed_q;
    logic [63:0] ln_lo [LANES];
    logic [63:0] ln_hi [LANES];
    logic [63:0] acc1, acc2;
    logic [63:0] pend [6];
    int unsigned npend;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_hash;

    t_hash       hash_q [$];
    int          errors;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    function automatic logic [63:0] rol(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    // Keyed pair mix: two full 128-bit products XORed.
    function automatic logic [127:0] pair_mix(input logic [63:0] m, input logic [63:0] y);
        logic [127:0] p1, p2;
        p1 = {64'd0, m ^ KEY_C0 ^ seed_q} * {64'd0, y ^ KEY_C1 ^ rol(seed_q, SEED_ROT)};
        p2 = {64'd0, m ^ KEY_C2 ^ seed_q} * {64'd0, y ^ KEY_C3};
        return p1 ^ p2;
    endfunction

    task automatic acc_cross();
        logic [63:0] t;
        t = acc1;
        acc1 = rol(acc1, 1) + acc2;
        acc2 = rol(t, 1) + acc1;
    endtask

    task automatic clear_msg();
        for (int i = 0; i < LANES; i++) begin
            ln_lo[i] = '0;
            ln_hi[i] = '0;
        end
        for (int i = 0; i < 6; i++) pend[i] = '0;
        acc1 = KEY_C1;
        acc2 = KEY_C0;
        npend = 0;
    endtask

    // Advance the predicted state by one chunk; push a hash on a last chunk.
    task automatic predict_chunk(input logic [63:0] wl, input logic [63:0] wh,
                                 input logic [4:0] bc_in, input logic lst);
        logic [127:0] pm;
        logic [63:0]  w [8];
        logic [63:0]  a1, a2, k0, k1, j0;
        int unsigned  bc, tail;
        logic         full;
        t_hash        h;
        bc = (bc_in > 16) ? 16 : bc_in;
        full = !lst || bc == 16;
        tail = 0;
        if (full) begin
            if (npend >= 3) begin
                for (int i = 0; i < 6; i++) w[i] = pend[i];
                w[6] = wl;
                w[7] = wh;
                for (int i = 0; i < LANES; i++) begin
                    pm = pair_mix(w[2*i], w[2*i+1]);
                    ln_lo[i] ^= pm[63:0];
                    ln_hi[i] ^= pm[127:64];
                end
                acc1 ^= ln_lo[0];
                acc2 ^= ln_hi[0];
                for (int i = 1; i < LANES; i++) begin
                    acc1 ^= rol(acc1, 1);
                    acc2 ^= rol(acc2, 1);
                    acc1 ^= ln_lo[i];
                    acc2 ^= ln_hi[i];
                end
                acc_cross();
                npend = 0;
            end else begin
                pend[2*npend]   = wl;
                pend[2*npend+1] = wh;
                npend++;
            end
        end
        if (!lst) return;
        // Leftover full chunks of an open group fold one at a time.
        for (int i = 0; i < npend; i++) begin
            pm = pair_mix(pend[2*i], pend[2*i+1]);
            acc1 ^= pm[63:0];
            acc2 ^= pm[127:64];
            acc_cross();
        end
        // Partial tail: zero-pad past the byte count, mix once.
        if (!full && bc > 0) begin
            if (bc < 8) begin
                wl &= (64'd1 << (8 * bc)) - 1;
                wh = '0;
            end else if (bc == 8) begin
                wh = '0;
            end else begin
                wh &= (64'd1 << (8 * (bc - 8))) - 1;
            end
            pm = pair_mix(wl, wh);
            acc1 ^= pm[63:0];
            acc2 ^= pm[127:64];
            tail = bc;
        end
        acc1 ^= 64'(tail);
        k0 = KEY_C0 ^ seed_q;
        k1 = KEY_C1 ^ rol(seed_q, SEED_ROT);
        j0 = KEY_C2 ^ seed_q;
        pm = ({64'd0, acc1} * {64'd0, j0}) ^ ({64'd0, acc2} * {64'd0, k0});
        a1 = pm[63:0] ^ pm[127:64];
        a2 = pm[127:64] + a1;
        a1 ^= a1 >> XS_SHIFT; a1 *= k0;
        a1 ^= a1 >> XS_SHIFT; a1 *= KEY_C3;
        a1 ^= a1 >> XS_SHIFT;
        a2 ^= a2 >> XS_SHIFT; a2 *= k1;
        a2 ^= a2 >> XS_SHIFT; a2 *= j0;
        a2 ^= a2 >> XS_SHIFT;
        h.lo = a1;
        h.hi = a2;
        hash_q.push_back(h);
        clear_msg();
    endtask

    // Offer one chunk; hold it steady until the core accepts the transaction.
    // Valid stays up afterwards so the next chunk can follow with no gap.
    task automatic send_chunk(input logic [63:0] wl, input logic [63:0] wh,
                              input logic [4:0] bc, input logic lst);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_word_low   <= wl;
        i_word_high  <= wh;
        i_byte_count <= bc;
        i_last       <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_chunk(wl, wh, bc, lst);
    endtask

    // Receiver: random stall, compare every accepted hash with the oldest expected.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (hash_q.size() == 0) begin
                $error("hash with nothing expected: %h %h", o_hash_low, o_hash_high);
                errors++;
            end else begin
                if (o_hash_low !== hash_q[0].lo) begin
                    $error("hash_low expected %h actual %h", hash_q[0].lo, o_hash_low);
                    errors++;
                end
                if (o_hash_high !== hash_q[0].hi) begin
                    $error("hash_high expected %h actual %h", hash_q[0].hi, o_hash_high);
                    errors++;
                end
                void'(hash_q.pop_front());
            end
        end
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // Let the queue drain and the core go idle before touching the seed.
    task automatic drain();
        i_valid <= 1'b0;
        while (hash_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        drain();
        i_seed_we <= 1'b1;
        i_seed    <= s;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
        seed_q = s;
    endtask

    // Message of n full chunks then a tail of tb bytes (tb 16 = full last chunk).
    task automatic send_msg(input int unsigned n, input int unsigned tb);
        for (int i = 0; i < n; i++) send_chunk(rnd64(), rnd64(), 5'd16, 1'b0);
        send_chunk(rnd64(), rnd64(), 5'(tb), 1'b1);
    endtask

    task automatic test_directed();
        send_chunk('0, '0, 5'd0, 1'b1);                     // empty message
        send_chunk('1, '1, 5'd16, 1'b1);                    // one full chunk
        send_chunk('1, '1, 5'd1, 1'b1);                     // tail of one byte
        send_chunk('1, '1, 5'd8, 1'b1);                     // tail on word boundary
        send_chunk('1, '1, 5'd15, 1'b1);
        send_chunk('1, '1, 5'd31, 1'b1);                    // count above 16
        send_chunk('1, '0, 5'd3, 1'b0);                     // short but not last
        send_chunk(rnd64(), rnd64(), 5'd9, 1'b1);
        send_msg(3, 16);                                    // group closed by last
        send_msg(3, 5);                                     // three folded singly
        send_msg(4, 0);                                     // group then empty
        send_msg(7, 12);
        send_msg(8, 16);
    endtask

    task automatic test_random(input int unsigned items);
        int unsigned cnt, n, tb;
        cnt = 0;
        while (cnt < items) begin
            n  = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
            tb = $urandom_range(16);
            if ($urandom_range(19) == 0) begin
                // noise: odd counts on non-last chunks
                send_chunk(rnd64(), rnd64(), 5'($urandom_range(31)), 1'b0);
                cnt++;
            end
            send_msg(n, ($urandom_range(15) == 0) ? 16 + $urandom_range(15) : tb);
            cnt += n + 1;
        end
    endtask

    task automatic test_phase(input logic [63:0] s, input int unsigned sp,
                              input int unsigned rp, input int unsigned items);
        write_seed(s);
        send_idle_pct  = sp;
        recv_stall_pct = rp;
        test_random(items);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        seed_q         = '0;
        i_rst_n        = 1'b0;
        i_seed_we      = 1'b0;
        i_seed         = '0;
        i_valid        = 1'b0;
        i_word_low     = '0;
        i_word_high    = '0;
        i_byte_count   = '0;
        i_last         = 1'b0;
        i_stall        = 1'b0;
        clear_msg();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();                                    // reset seed of zero
        test_phase('1, 0, 0, 250);
        test_phase(rnd64(), 61, 0, 250);
        // sender waits for every hash before going on
        drain();
        test_phase(rnd64(), 0, 61, 250);
        test_phase(64'h8000_0000_0000_0001, 37, 37, 250);
        test_phase('0, 0, 0, 150);
        drain();

        if (errors == 0) begin
            $display("seeded_128bit_multiply_mix_hash_core regression: pass");
        end else begin
            $display("seeded_128bit_multiply_mix_hash_core regression: fail");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("seeded_128bit_multiply_mix_hash_core regression: fail");
        $finish;
    end

endmodule
